>>> hdl/aig_node_leveler_unit_macros.svh
// ----------------------------------------------------------------------------
// aig_node_leveler_unit_macros.svh
// Assertion macros shared by the leveler checker.
// ----------------------------------------------------------------------------
`ifndef AIG_NODE_LEVELER_UNIT_MACROS_SVH
`define AIG_NODE_LEVELER_UNIT_MACROS_SVH

// Generic clocked assertion with reset guard.
`define AIGNL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Same, on the unit's own clock and reset.
`define AIGNL_ASSERT_CLK(lbl, prop, msg) \
   `AIGNL_ASSERT(lbl, clock, reset, prop, msg)

`endif

>>> hdl/aignl_pkg.sv
// ----------------------------------------------------------------------------
// aignl_pkg
// Types and constants for the and-inverter graph leveler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aignl_pkg;

   // Level table size and address width
   localparam int MAX_NODES = 65536;
   localparam int ADDR_W    = $clog2(MAX_NODES);

   // Level and statistics widths
   localparam int LEVEL_W = 16;
   localparam int ID_W    = 16;
   localparam int SUM_W   = 32;
   localparam int COUNT_W = 17;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

   // Configuration register map
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_CTRL = 1'b0;

   // Item actions
   typedef enum logic [1:0] {
      ACT_SOURCE  = 2'd0,
      ACT_AND     = 2'd1,
      ACT_OUTPUT  = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   // Input item
   typedef struct packed {
      action_type         action;
      logic [ID_W-1:0]    node_id;
      logic [ID_W-1:0]    fanin_a_id;
      logic [ID_W-1:0]    fanin_b_id;
      logic               is_latch;
   } req_type;

   // Result item
   typedef struct packed {
      logic [LEVEL_W-1:0] node_level;
      logic [LEVEL_W-1:0] max_level;
      logic [LEVEL_W-1:0] min_level;
      logic [SUM_W-1:0]   level_sum;
      logic [COUNT_W-1:0] output_count;
   } rsp_type;

   // Statistics update command
   typedef struct packed {
      logic               update;
      logic               clear;
      logic [LEVEL_W-1:0] level;
   } stats_cmd_type;

   // Running statistics
   typedef struct packed {
      logic [LEVEL_W-1:0] max_level;
      logic [LEVEL_W-1:0] min_level;
      logic [SUM_W-1:0]   level_sum;
      logic [COUNT_W-1:0] output_count;
   } stats_type;

endpackage

>>> hdl/aignl_ram.sv
// ----------------------------------------------------------------------------
// aignl_ram
// Synchronous RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aignl_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 65536,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output logic [DATA_W-1:0] rd_a_data,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [DATA_W-1:0] rd_b_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports, registered
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

>>> hdl/aignl_stats.sv
// ----------------------------------------------------------------------------
// aignl_stats
// Running max, min, sum and count of output levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aignl_stats (
   input  logic                     clock,
   input  logic                     reset,
   input  aignl_pkg::stats_cmd_type cmd,
   output aignl_pkg::stats_type     stats
);

   logic [aignl_pkg::LEVEL_W-1:0] max_ff, max_in;
   logic [aignl_pkg::LEVEL_W-1:0] min_ff, min_in;
   logic [aignl_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [aignl_pkg::COUNT_W-1:0] count_ff, count_in;

   // Next values: clear wins, else fold in the new level
   always_comb begin
      max_in   = max_ff;
      min_in   = min_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         max_in   = '0;
         min_in   = aignl_pkg::LEVEL_MAX;
         sum_in   = '0;
         count_in = '0;
      end else if (cmd.update) begin
         if (cmd.level > max_ff) begin
            max_in = cmd.level;
         end
         if (cmd.level < min_ff) begin
            min_in = cmd.level;
         end
         sum_in   = sum_ff + aignl_pkg::SUM_W'(cmd.level);
         count_in = count_ff + aignl_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= '0;
         min_ff   <= aignl_pkg::LEVEL_MAX;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         max_ff   <= max_in;
         min_ff   <= min_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   assign stats.max_level    = max_ff;
   assign stats.min_level    = min_ff;
   assign stats.level_sum    = sum_ff;
   assign stats.output_count = count_ff;

endmodule

>>> hdl/aig_node_leveler_unit.sv
// ----------------------------------------------------------------------------
// aig_node_leveler_unit
// Levels and-inverter graph nodes streamed in topological order.
// ----------------------------------------------------------------------------
//   Channel   Ports                          Transfer
//   request   start, busy, req_data          start high and busy low
//   response  rsp_valid, rsp_data            one cycle per strobe, no stall
//   config    psel/penable/pwrite/paddr/...  APB access phase, pready high
//
// Fanin levels are read from the level table in the accept cycle, the level is
// formed and written back in the next, and the result shows in the cycle after.
// The table's read is registered.
// Reset clears control and statistics; the level table has no reset.
// The response side cannot stall; busy holds off the next item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aig_node_leveler_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             start,
   output logic                             busy,
   input  aignl_pkg::req_type               req_data,
   // response
   output logic                             rsp_valid,
   output aignl_pkg::rsp_type               rsp_data,
   // configuration
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [aignl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   logic                            accept;
   logic                            busy_ff, busy_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            latch_as_co_ff, latch_as_co_in;
   aignl_pkg::req_type              item_ff;
   logic                            node_ok_ff, fa_ok_ff, fb_ok_ff;
   logic [aignl_pkg::LEVEL_W-1:0]   level_ff;
   logic [aignl_pkg::LEVEL_W-1:0]   rd_a_data, rd_b_data;
   logic [aignl_pkg::LEVEL_W-1:0]   lvl_a, lvl_b, lvl_max, lvl_new;
   logic                            wr_req, wr_en;
   logic                            csr_wr;
   aignl_pkg::stats_cmd_type        stats_cmd;
   aignl_pkg::stats_type            stats;

   assign accept = start && !busy_ff;

   // Configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      latch_as_co_in = latch_as_co_ff;
      if (csr_wr && paddr[2] == aignl_pkg::CSR_IDX_CTRL) begin
         latch_as_co_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == aignl_pkg::CSR_IDX_CTRL) begin
         prdata = {31'b0, latch_as_co_ff};
      end
   end

   // Level table
   aignl_ram #(
      .DATA_W (aignl_pkg::LEVEL_W),
      .DEPTH  (aignl_pkg::MAX_NODES)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (aignl_pkg::ADDR_W'(item_ff.node_id)),
      .wr_data   (lvl_new),
      .rd_a_addr (aignl_pkg::ADDR_W'(req_data.fanin_a_id)),
      .rd_a_data (rd_a_data),
      .rd_b_addr (aignl_pkg::ADDR_W'(req_data.fanin_b_id)),
      .rd_b_data (rd_b_data)
   );

   // Capture the item and its range checks at accept
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff    <= req_data;
         node_ok_ff <= 32'(req_data.node_id) < aignl_pkg::MAX_NODES;
         fa_ok_ff   <= 32'(req_data.fanin_a_id) < aignl_pkg::MAX_NODES;
         fb_ok_ff   <= 32'(req_data.fanin_b_id) < aignl_pkg::MAX_NODES;
      end
   end

   // Out-of-range fanins read as zero
   assign lvl_a   = fa_ok_ff ? rd_a_data : '0;
   assign lvl_b   = fb_ok_ff ? rd_b_data : '0;
   assign lvl_max = (lvl_a > lvl_b) ? lvl_a : lvl_b;

   // Level and write decision per action
   always_comb begin
      lvl_new = '0;
      wr_req  = 1'b0;
      unique case (item_ff.action)
         aignl_pkg::ACT_SOURCE: begin
            wr_req = 1'b1;
         end
         aignl_pkg::ACT_AND: begin
            // saturate at the top level
            lvl_new = (lvl_max == aignl_pkg::LEVEL_MAX) ? aignl_pkg::LEVEL_MAX
                                                       : lvl_max + 1'b1;
            wr_req  = 1'b1;
         end
         aignl_pkg::ACT_OUTPUT: begin
            lvl_new = lvl_a;
            wr_req  = !item_ff.is_latch || latch_as_co_ff;
         end
         aignl_pkg::ACT_RESTART: begin
            wr_req = 1'b0;
         end
         default: begin
            wr_req = 1'b0;
         end
      endcase
   end

   assign wr_en = busy_ff && wr_req && node_ok_ff;

   // Statistics
   assign stats_cmd.update = busy_ff && item_ff.action == aignl_pkg::ACT_OUTPUT;
   assign stats_cmd.clear  = busy_ff && item_ff.action == aignl_pkg::ACT_RESTART;
   assign stats_cmd.level  = lvl_a;

   aignl_stats u_stats (
      .clock (clock),
      .reset (reset),
      .cmd   (stats_cmd),
      .stats (stats)
   );

   // Control: busy for the processing cycle, strobe the cycle after
   assign busy_in      = accept;
   assign rsp_valid_in = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         latch_as_co_ff <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         rsp_valid_ff   <= rsp_valid_in;
         latch_as_co_ff <= latch_as_co_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         level_ff <= lvl_new;
      end
   end

   // Outputs
   assign busy                  = busy_ff;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.node_level   = level_ff;
   assign rsp_data.max_level    = stats.max_level;
   assign rsp_data.min_level    = stats.min_level;
   assign rsp_data.level_sum    = stats.level_sum;
   assign rsp_data.output_count = stats.output_count;

endmodule

>>> hdl/aignl_checker.sv
// ----------------------------------------------------------------------------
// aignl_checker
// Port-level checks on the leveler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aig_node_leveler_unit_macros.svh"

module aignl_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input aignl_pkg::req_type req_data,
   input logic               rsp_valid,
   input aignl_pkg::rsp_type rsp_data
);

   logic xfer_in;
   logic restart_in;
   logic stats_clear;

   // Transfer in, restart transfer and cleared statistics on the result
   assign xfer_in     = start && !busy;
   assign restart_in  = xfer_in && req_data.action == aignl_pkg::ACT_RESTART;
   assign stats_clear = rsp_data.output_count == '0 && rsp_data.level_sum == '0 &&
                        rsp_data.min_level == aignl_pkg::LEVEL_MAX &&
                        rsp_data.max_level == '0;

   // Every transfer in is followed by a result
   `AIGNL_ASSERT_CLK(a_result_follows, xfer_in |-> ##2 rsp_valid, "missing result")

   // Results never come in consecutive cycles
   `AIGNL_ASSERT_CLK(a_no_double, rsp_valid |=> !rsp_valid, "result repeated")

   // No result without an earlier transfer in
   `AIGNL_ASSERT_CLK(a_no_phantom, rsp_valid |-> $past(busy), "result without item")

   // A restart returns cleared statistics
   `AIGNL_ASSERT_CLK(a_restart_clears, restart_in |-> ##2 stats_clear, "restart did not clear")

endmodule

bind aig_node_leveler_unit aignl_checker u_aignl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

>>> tb/aig_node_leveler_unit_tb.sv
// ----------------------------------------------------------------------------
// aig_node_leveler_unit_tb
// Self-checking bench for the and-inverter graph leveler.
// ----------------------------------------------------------------------------
// A short table of directed items is walked first. Some rows carry their
// result typed in; the rest are checked against a level predictor held in
// the bench. Random netlist fragments follow under both settings of
// latch_as_co, with bursts of idle on the request side; the last stretch of
// the final phase runs without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aig_node_leveler_unit_tb;

   localparam int STALL_LIMIT = 1000;
   localparam logic [aignl_pkg::CSR_ADDR_W-1:0] CTRL_ADDR =
      aignl_pkg::CSR_ADDR_W'(4 * int'(aignl_pkg::CSR_IDX_CTRL));

   typedef struct {
      bit                 is_cfg;
      bit                 cfg_val;
      aignl_pkg::req_type item;
      bit                 typed;
      aignl_pkg::rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   aignl_pkg::req_type req_data = '0;
   logic    rsp_valid;
   aignl_pkg::rsp_type rsp_data;
   logic    psel = 1'b0;
   logic    penable = 1'b0;
   logic    pwrite = 1'b0;
   logic [aignl_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic    pready;

   // Predictor state: level table, statistics and control copy
   logic [aignl_pkg::LEVEL_W-1:0] level_mem [0:aignl_pkg::MAX_NODES-1];
   bit                            level_known [0:aignl_pkg::MAX_NODES-1];
   logic [aignl_pkg::ID_W-1:0]    known_ids [$];
   logic [aignl_pkg::LEVEL_W-1:0] max_seen;
   logic [aignl_pkg::LEVEL_W-1:0] min_seen;
   logic [aignl_pkg::SUM_W-1:0]   sum_seen;
   logic [aignl_pkg::COUNT_W-1:0] count_seen;
   bit                            latch_mode;

   aignl_pkg::rsp_type pending_levels [$];
   stim_row_type       stim_table [$];
   int                 errors = 0;
   int                 stall_cycles = 0;
   bit                 bursty = 1'b0;

   aig_node_leveler_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Mismatch reporting; printing is capped, counting is not
   task automatic report(input string msg);
      errors++;
      if (errors <= 40) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   // Level table write, mirroring the block's store
   function automatic void store_level(input logic [aignl_pkg::ID_W-1:0] id,
                                       input logic [aignl_pkg::LEVEL_W-1:0] lvl);
      level_mem[id] = lvl;
      if (!level_known[id]) begin
         level_known[id] = 1'b1;
         known_ids.insert(known_ids.size(), id);
      end
   endfunction

   function automatic void clear_stats();
      max_seen   = '0;
      min_seen   = aignl_pkg::LEVEL_MAX;
      sum_seen   = '0;
      count_seen = '0;
   endfunction

   // Levels one node and updates the statistics
   function automatic aignl_pkg::rsp_type level_node(input aignl_pkg::req_type r);
      logic [aignl_pkg::LEVEL_W-1:0] lvl;
      logic [aignl_pkg::LEVEL_W-1:0] la;
      logic [aignl_pkg::LEVEL_W-1:0] lb;
      logic [aignl_pkg::LEVEL_W-1:0] deeper;
      aignl_pkg::rsp_type res;
      lvl = '0;
      case (r.action)
         aignl_pkg::ACT_SOURCE: begin
            store_level(r.node_id, '0);
         end
         aignl_pkg::ACT_AND: begin
            la = level_mem[r.fanin_a_id];
            lb = level_mem[r.fanin_b_id];
            deeper = (la > lb) ? la : lb;
            lvl = (deeper == aignl_pkg::LEVEL_MAX) ? aignl_pkg::LEVEL_MAX
                                                   : deeper + 1'b1;
            store_level(r.node_id, lvl);
         end
         aignl_pkg::ACT_OUTPUT: begin
            lvl = level_mem[r.fanin_a_id];
            if (!r.is_latch || latch_mode) begin
               store_level(r.node_id, lvl);
            end
            if (lvl > max_seen) max_seen = lvl;
            if (lvl < min_seen) min_seen = lvl;
            sum_seen   = sum_seen + aignl_pkg::SUM_W'(lvl);
            count_seen = count_seen + 1'b1;
         end
         default: begin
            clear_stats();
         end
      endcase
      res.node_level   = lvl;
      res.max_level    = max_seen;
      res.min_level    = min_seen;
      res.level_sum    = sum_seen;
      res.output_count = count_seen;
      return res;
   endfunction

   // Picks an already levelled node, mostly a recent one to grow depth
   function automatic logic [aignl_pkg::ID_W-1:0] pick_known();
      int n;
      n = known_ids.size();
      if (n > 16 && $urandom_range(0, 3) != 0) begin
         return known_ids[$urandom_range(n - 16, n - 1)];
      end
      return known_ids[$urandom_range(0, n - 1)];
   endfunction

   function automatic aignl_pkg::req_type random_item();
      aignl_pkg::req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)       r.action = aignl_pkg::ACT_SOURCE;
      else if (pick < 55)  r.action = aignl_pkg::ACT_AND;
      else if (pick < 94)  r.action = aignl_pkg::ACT_OUTPUT;
      else                 r.action = aignl_pkg::ACT_RESTART;
      r.node_id    = ($urandom_range(0, 9) < 7) ? aignl_pkg::ID_W'($urandom)
                                                : pick_known();
      r.fanin_a_id = pick_known();
      r.fanin_b_id = pick_known();
      r.is_latch   = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Drives one item and waits for its transfer
   task automatic send_item(input aignl_pkg::req_type r, input bit typed,
                            input aignl_pkg::rsp_type want);
      aignl_pkg::rsp_type predicted;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = level_node(r);
      pending_levels.insert(pending_levels.size(), typed ? want : predicted);
   endtask

   task automatic idle_for(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Holds requests off until every result is back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   // Control register write, then read back
   task automatic write_ctrl(input bit val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CTRL_ADDR;
      pwdata  <= {31'b0, val};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      latch_mode = val;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("latch_as_co readback", {31'b0, prdata[0]}, {31'b0, val});
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic add_row(input bit is_cfg, input bit cfg_val,
                          input aignl_pkg::action_type act,
                          input logic [aignl_pkg::ID_W-1:0] node,
                          input logic [aignl_pkg::ID_W-1:0] fa,
                          input logic [aignl_pkg::ID_W-1:0] fb, input bit latch,
                          input bit typed, input aignl_pkg::rsp_type want);
      stim_row_type row;
      row.is_cfg  = is_cfg;
      row.cfg_val = cfg_val;
      row.item    = '{action: act, node_id: node, fanin_a_id: fa,
                      fanin_b_id: fb, is_latch: latch};
      row.typed   = typed;
      row.want    = want;
      stim_table.insert(stim_table.size(), row);
   endtask

   // Result checking against the oldest expectation
   always @(posedge clock) begin
      aignl_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_levels.size() == 0) begin
            report("result with nothing expected");
         end else begin
            want = pending_levels.pop_front();
            check_field("node_level", 32'(rsp_data.node_level), 32'(want.node_level));
            check_field("max_level", 32'(rsp_data.max_level), 32'(want.max_level));
            check_field("min_level", 32'(rsp_data.min_level), 32'(want.min_level));
            check_field("level_sum", rsp_data.level_sum, want.level_sum);
            check_field("output_count", 32'(rsp_data.output_count),
                        32'(want.output_count));
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      aignl_pkg::rsp_type blank;
      stim_row_type row;
      blank = '{node_level: '0, max_level: '0, min_level: aignl_pkg::LEVEL_MAX,
                level_sum: '0, output_count: '0};
      for (int i = 0; i < aignl_pkg::MAX_NODES; i++) level_known[i] = 1'b0;
      clear_stats();
      latch_mode = 1'b0;

      // Directed rows: extremes, every action, latch handling, restart
      add_row('0, '0, aignl_pkg::ACT_SOURCE,  16'h0000, 16'h0000, 16'h0000, '0, '1, blank);
      add_row('0, '0, aignl_pkg::ACT_SOURCE,  16'hffff, 16'h0000, 16'h0000, '1, '1, blank);
      add_row('0, '0, aignl_pkg::ACT_AND,     16'h0001, 16'h0000, 16'hffff, '0, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_AND,     16'h0002, 16'h0001, 16'h0000, '1, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_AND,     16'haaaa, 16'h0002, 16'h0001, '0, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_AND,     16'h5555, 16'hffff, 16'hffff, '0, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_OUTPUT,  16'h0100, 16'haaaa, 16'h5555, '0, '0, blank);
      // latch record with the control bit clear leaves node 0 at level 0
      add_row('0, '0, aignl_pkg::ACT_OUTPUT,  16'h0000, 16'h0002, 16'haaaa, '1, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_AND,     16'h0003, 16'h0000, 16'h0000, '0, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_OUTPUT,  16'h0101, 16'hffff, 16'h0000, '0, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_RESTART, 16'hffff, 16'hffff, 16'hffff, '1, '1, blank);
      add_row('0, '0, aignl_pkg::ACT_OUTPUT,  16'h0102, 16'h5555, 16'haaaa, '0, '0, blank);
      add_row('1, '1, aignl_pkg::ACT_SOURCE,  16'h0000, 16'h0000, 16'h0000, '0, '0, blank);
      // latch record now writes through
      add_row('0, '0, aignl_pkg::ACT_OUTPUT,  16'h0000, 16'haaaa, 16'h0001, '1, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_AND,     16'h0004, 16'h0000, 16'h5555, '0, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_OUTPUT,  16'hffff, 16'h0004, 16'h0002, '1, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_AND,     16'h0005, 16'hffff, 16'hffff, '1, '0, blank);
      add_row('1, '0, aignl_pkg::ACT_SOURCE,  16'h0000, 16'h0000, 16'h0000, '0, '0, blank);
      add_row('0, '0, aignl_pkg::ACT_RESTART, 16'h0000, 16'h0000, 16'h0000, '0, '1, blank);
      add_row('0, '0, aignl_pkg::ACT_SOURCE,  16'h0004, 16'h0005, 16'h0003, '1, '1, blank);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.is_cfg) begin
            drain();
            write_ctrl(row.cfg_val);
         end else begin
            send_item(row.item, row.typed, row.want);
         end
      end

      // Random netlist fragments under alternating control settings;
      // the tail of the last phase runs without idling
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         write_ctrl(~phase[0]);
         for (int n = 0; n < 300; n++) begin
            send_item(random_item(), 1'b0, blank);
            if (n % 40 == 0) bursty = 1'($urandom_range(0, 1));
            if (bursty && !(phase == 3 && n >= 220) && $urandom_range(0, 2) == 0) begin
               idle_for($urandom_range(1, 12));
            end
            if (phase == 1 && n == 150) drain();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (pending_levels.size() != 0) begin
         report($sformatf("%0d results never arrived", pending_levels.size()));
      end
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
